[rtl/core/assert_macros.svh]
// assertion macros shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("core assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("core assertion failed");

`endif

[rtl/core/ibf_pkg.sv]
// shared types, constants and register codes of the box filter core
package ibf_pkg;

	localparam int PIX_W      = 32;
	localparam int COORD_W    = 9;
	localparam int CFG_W      = 10;
	localparam int HALF_CFG_W = 7;
	localparam int CFG_IDX_W  = 2;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_MAX_HALF   = 64;

	localparam int WIDTH_RST  = 64;
	localparam int HEIGHT_RST = 64;
	localparam int HALF_RST   = 8;

	localparam int OUT_DEPTH = 4;

	// forwarding flag positions, one per line store read
	localparam int FWD_PREV   = 0;
	localparam int FWD_CUR_X0 = 1;
	localparam int FWD_OLD_X0 = 2;
	localparam int FWD_OLD_C  = 3;
	localparam int FWD_N      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_HALF_HEIGHT  = 2'd2,
		CFG_HALF_WIDTH   = 2'd3
	} cfg_idx_t;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic             valid;
		logic             emit;
		logic             is_last;
		logic             top_row;
		logic [FWD_N-1:0] fwd;
		coord_t           x;
		coord_t           y;
		pix_t             rowsum;
	} s1_ctrl_t;

	typedef struct packed {
		pix_t   box_sum;
		coord_t out_x;
		coord_t out_y;
		logic   last_of_frame;
	} box_word_t;

endpackage

[rtl/core/ibf_pix_if.sv]
// pixel input channel
interface ibf_pix_if;
	import ibf_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_value;

	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);
endinterface

[rtl/core/ibf_box_if.sv]
// box sum output channel
interface ibf_box_if;
	import ibf_pkg::*;

	logic   valid;
	logic   ready;
	pix_t   box_sum;
	coord_t out_x;
	coord_t out_y;
	logic   last_of_frame;

	modport source(output valid, output box_sum, output out_x, output out_y,
		output last_of_frame, input ready);
	modport sink(input valid, input box_sum, input out_x, input out_y,
		input last_of_frame, output ready);
endinterface

[rtl/core/ibf_line_store.sv]
// integral row ring memory, one write port and two registered read ports
module ibf_line_store #(
	parameter int AW = 16
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ibf_pkg::pix_t   wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr0,
	input  logic [AW-1:0]   raddr1,
	output ibf_pkg::pix_t   rdata0,
	output ibf_pkg::pix_t   rdata1
);
	import ibf_pkg::*;

	pix_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

[rtl/core/ibf_ctrl.sv]
// configuration, raster counters, row ring addressing and read hazard detection
`include "assert_macros.svh"

module ibf_ctrl #(
	parameter int MAX_WIDTH  = ibf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ibf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_HALF   = ibf_pkg::DEF_MAX_HALF,
	localparam int AW = $clog2(2 * MAX_HALF) + $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ibf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ibf_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             accept,
	input  ibf_pkg::pix_t                    pixel_value,
	output logic [AW-1:0]                    rd_prev_addr,
	output logic [AW-1:0]                    rd_cur_x0_addr,
	output logic [AW-1:0]                    rd_old_x0_addr,
	output logic [AW-1:0]                    rd_old_c_addr,
	output logic [AW-1:0]                    wr_addr_s1,
	output ibf_pkg::s1_ctrl_t                ctrl_s1
);
	import ibf_pkg::*;

	localparam int COLW  = $clog2(MAX_WIDTH);
	localparam int ROWW  = $clog2(MAX_HEIGHT);
	localparam int RING  = 2 * MAX_HALF;
	localparam int SLOTW = $clog2(RING);
	localparam int SPANW = $clog2(RING);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HTW   = $clog2(MAX_HEIGHT + 1);
	localparam int HALFW = $clog2(MAX_HALF + 1);

	localparam int W_RST  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
	localparam int H_RST  = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;
	localparam int HF_RST = (HALF_RST > MAX_HALF) ? MAX_HALF : HALF_RST;

	logic [WW-1:0]    w_q;
	logic [HTW-1:0]   h_q;
	logic [HALFW-1:0] hh_q;
	logic [HALFW-1:0] hw_q;

	logic [WW-1:0]         clamp_w;
	logic [HTW-1:0]        clamp_h;
	logic [HALF_CFG_W-1:0] half_raw;
	logic [HALFW-1:0]      clamp_half;

	logic [COLW-1:0]  c_q;
	logic [ROWW-1:0]  r_q;
	logic [SLOTW-1:0] slot_q;
	pix_t             rowsum_q;

	logic [SPANW-1:0] spanx;
	logic [SPANW-1:0] spany;
	logic [COLW-1:0]  x0;
	logic [ROWW-1:0]  y0;
	logic [SLOTW-1:0] slot_prev;
	logic [SLOTW-1:0] slot_y0;
	logic             emit;
	logic             is_last;
	logic             row_end;
	logic             frame_end;
	pix_t             rowsum_nxt;
	logic [FWD_N-1:0] fwd;

	// register writes, values clamped on the way in
	always_comb begin
		half_raw = cfg_data[HALF_CFG_W-1:0];
		if (cfg_data == '0) begin
			clamp_w = WW'(1);
			clamp_h = HTW'(1);
		end else begin
			clamp_w = (int'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
			clamp_h = (int'(cfg_data) > MAX_HEIGHT) ? HTW'(MAX_HEIGHT) : HTW'(cfg_data);
		end
		clamp_half = (int'(half_raw) > MAX_HALF) ? HALFW'(MAX_HALF) : HALFW'(half_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WW'(W_RST);
			h_q  <= HTW'(H_RST);
			hh_q <= HALFW'(HF_RST);
			hw_q <= HALFW'(HF_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  w_q  <= clamp_w;
				CFG_FRAME_HEIGHT: h_q  <= clamp_h;
				CFG_HALF_HEIGHT:  hh_q <= clamp_half;
				CFG_HALF_WIDTH:   hw_q <= clamp_half;
				default: ;
			endcase
		end
	end

	// window geometry and ring addressing for the pixel at (r_q, c_q)
	always_comb begin
		spanx = SPANW'(2 * int'(hw_q) - 1);
		spany = SPANW'(2 * int'(hh_q) - 1);
		x0    = COLW'(int'(c_q) - int'(spanx));
		y0    = ROWW'(int'(r_q) - int'(spany));
		emit  = (hh_q != '0) && (hw_q != '0)
			&& (int'(c_q) >= int'(spanx)) && (int'(r_q) >= int'(spany))
			&& (int'(c_q) + 2 <= int'(w_q)) && (int'(r_q) + 2 <= int'(h_q));
		is_last   = (int'(c_q) + 2 == int'(w_q)) && (int'(r_q) + 2 == int'(h_q));
		row_end   = int'(c_q) + 1 >= int'(w_q);
		frame_end = int'(r_q) + 1 >= int'(h_q);
		slot_prev = (slot_q == '0) ? SLOTW'(RING - 1) : slot_q - SLOTW'(1);
		slot_y0   = (int'(slot_q) >= int'(spany))
			? SLOTW'(int'(slot_q) - int'(spany))
			: SLOTW'(int'(slot_q) + RING - int'(spany));
		rowsum_nxt = ((c_q == '0) ? pix_t'(0) : rowsum_q) + pixel_value;

		rd_prev_addr   = {slot_prev, c_q};
		rd_cur_x0_addr = {slot_q, x0};
		rd_old_x0_addr = {slot_y0, x0};
		rd_old_c_addr  = {slot_y0, c_q};

		// the word written this cycle is not yet visible to these reads
		fwd[FWD_PREV]   = ctrl_s1.valid && (rd_prev_addr == wr_addr_s1);
		fwd[FWD_CUR_X0] = ctrl_s1.valid && (rd_cur_x0_addr == wr_addr_s1);
		fwd[FWD_OLD_X0] = ctrl_s1.valid && (rd_old_x0_addr == wr_addr_s1);
		fwd[FWD_OLD_C]  = ctrl_s1.valid && (rd_old_c_addr == wr_addr_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q      <= '0;
			r_q      <= '0;
			slot_q   <= '0;
			rowsum_q <= '0;
		end else if (accept) begin
			rowsum_q <= rowsum_nxt;
			if (row_end) begin
				c_q <= '0;
				if (frame_end) begin
					r_q    <= '0;
					slot_q <= '0;
				end else begin
					r_q    <= r_q + ROWW'(1);
					slot_q <= (slot_q == SLOTW'(RING - 1)) ? '0 : slot_q + SLOTW'(1);
				end
			end else begin
				c_q <= c_q + COLW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= accept;
			if (accept) begin
				ctrl_s1.emit    <= emit;
				ctrl_s1.is_last <= is_last;
				ctrl_s1.top_row <= (r_q == '0);
				ctrl_s1.fwd     <= fwd;
				ctrl_s1.x       <= COORD_W'(x0);
				ctrl_s1.y       <= COORD_W'(y0);
				ctrl_s1.rowsum  <= rowsum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_addr_s1 <= {slot_q, c_q};
		end
	end

	`ASSERT_IMPLY(a_slot_in_ring, clk, arst_n, 1'b1, int'(slot_q) < RING)
	`ASSERT_IMPLY(a_slot_frame_top, clk, arst_n, r_q == '0, slot_q == '0)
	`ASSERT_NEXT(a_frame_wrap, clk, arst_n, accept && row_end && frame_end, c_q == '0 && r_q == '0 && slot_q == '0)
endmodule

[rtl/core/ibf_sum.sv]
// integral value update, write-back data and corner arithmetic
`include "assert_macros.svh"

module ibf_sum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ibf_pkg::s1_ctrl_t     ctrl_s1,
	input  ibf_pkg::pix_t         prev_rd,
	input  ibf_pkg::pix_t         cur_x0_rd,
	input  ibf_pkg::pix_t         old_x0_rd,
	input  ibf_pkg::pix_t         old_c_rd,
	output logic                  we,
	output ibf_pkg::pix_t         wr_data,
	output logic                  push,
	output ibf_pkg::box_word_t    push_word
);
	import ibf_pkg::*;

	pix_t   last_val_q;
	pix_t   prev;
	pix_t   cur_x0;
	pix_t   old_x0;
	pix_t   old_c;
	pix_t   val;

	logic   v_s2;
	logic   is_last_s2;
	coord_t x_s2;
	coord_t y_s2;
	pix_t   val_s2;
	pix_t   cur_x0_s2;
	pix_t   dy_s2;

	always_comb begin
		prev   = ctrl_s1.fwd[FWD_PREV]   ? last_val_q : prev_rd;
		cur_x0 = ctrl_s1.fwd[FWD_CUR_X0] ? last_val_q : cur_x0_rd;
		old_x0 = ctrl_s1.fwd[FWD_OLD_X0] ? last_val_q : old_x0_rd;
		old_c  = ctrl_s1.fwd[FWD_OLD_C]  ? last_val_q : old_c_rd;
		val    = ctrl_s1.rowsum + (ctrl_s1.top_row ? pix_t'(0) : prev);
		we      = ctrl_s1.valid;
		wr_data = val;
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			last_val_q <= val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl_s1.valid && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid && ctrl_s1.emit) begin
			val_s2     <= val;
			cur_x0_s2  <= cur_x0;
			dy_s2      <= old_x0 - old_c;
			x_s2       <= ctrl_s1.x;
			y_s2       <= ctrl_s1.y;
			is_last_s2 <= ctrl_s1.is_last;
		end
	end

	always_comb begin
		push                    = v_s2;
		push_word.box_sum       = val_s2 - cur_x0_s2 + dy_s2;
		push_word.out_x         = x_s2;
		push_word.out_y         = y_s2;
		push_word.last_of_frame = is_last_s2;
	end

	`ASSERT_IMPLY(a_fwd_after_write, clk, arst_n, ctrl_s1.valid && ctrl_s1.fwd != '0, $past(ctrl_s1.valid))
endmodule

[rtl/core/ibf_out_fifo.sv]
// output word queue driving the result channel
`include "assert_macros.svh"

module ibf_out_fifo #(
	parameter int DEPTH = ibf_pkg::OUT_DEPTH,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ibf_pkg::box_word_t   push_word,
	ibf_box_if.source            box,
	output logic [CW-1:0]        count
);
	import ibf_pkg::*;

	localparam int PW = $clog2(DEPTH);

	box_word_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	box_word_t       head;

	always_comb begin
		head              = entry_q[rd_ptr_q];
		box.valid         = (count_q != '0);
		box.box_sum       = head.box_sum;
		box.out_x         = head.out_x;
		box.out_y         = head.out_y;
		box.last_of_frame = head.last_of_frame;
		pop               = box.valid && box.ready;
		count             = count_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, int'(count_q) < DEPTH)
endmodule

[rtl/core/integral_image_box_filter_top.sv]
// top level of the integral image box sum filter
//
// pix carries one signed 32-bit pixel per word in raster order; box carries one
// window sum per word with its origin column and row and a flag on the last
// window of the frame. cfg_we, cfg_index and cfg_data write frame_width,
// frame_height, half_height and half_width; write them only while no word is
// in flight. a pixel is taken at a rising edge with valid and ready high.
// throughput is one pixel per cycle while pix.ready is high: the four corner
// reads of a pixel go to two copies of the row ring, each with two read ports,
// while both copies take the new integral value on their write port. a window
// sum passes through the row ring read, the integral update, the corner sum
// and the output queue on its way to box. reset clears the counters and loads
// the default sizes; the row ring is not cleared and needs no clearing pass.
// when the receiver stalls, results collect in a four-entry queue and pix.ready
// falls once queued and in-flight results could fill it, so no word is lost.
module integral_image_box_filter_top #(
	parameter int MAX_WIDTH  = ibf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ibf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_HALF   = ibf_pkg::DEF_MAX_HALF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ibf_pix_if.sink                        pix,
	ibf_box_if.source                      box,
	input  logic                           cfg_we,
	input  logic [ibf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ibf_pkg::CFG_W-1:0]      cfg_data
);
	import ibf_pkg::*;

	localparam int AW  = $clog2(2 * MAX_HALF) + $clog2(MAX_WIDTH);
	localparam int CNW = $clog2(OUT_DEPTH + 1);

	logic            accept;
	logic [AW-1:0]   rd_prev_addr;
	logic [AW-1:0]   rd_cur_x0_addr;
	logic [AW-1:0]   rd_old_x0_addr;
	logic [AW-1:0]   rd_old_c_addr;
	logic [AW-1:0]   wr_addr_s1;
	s1_ctrl_t        ctrl_s1;
	pix_t            prev_rd;
	pix_t            cur_x0_rd;
	pix_t            old_x0_rd;
	pix_t            old_c_rd;
	logic            we;
	pix_t            wr_data;
	logic            push;
	box_word_t       push_word;
	logic [CNW-1:0]  fifo_count;

	assign pix.ready = (int'(fifo_count) + int'(ctrl_s1.valid && ctrl_s1.emit)
		+ int'(push)) < OUT_DEPTH;
	assign accept = pix.valid && pix.ready;

	ibf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_HALF   (MAX_HALF)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.pixel_value    (pix.pixel_value),
		.rd_prev_addr   (rd_prev_addr),
		.rd_cur_x0_addr (rd_cur_x0_addr),
		.rd_old_x0_addr (rd_old_x0_addr),
		.rd_old_c_addr  (rd_old_c_addr),
		.wr_addr_s1     (wr_addr_s1),
		.ctrl_s1        (ctrl_s1)
	);

	ibf_line_store #(.AW(AW)) u_store_a (
		.clk    (clk),
		.we     (we),
		.waddr  (wr_addr_s1),
		.wdata  (wr_data),
		.re     (accept),
		.raddr0 (rd_prev_addr),
		.raddr1 (rd_cur_x0_addr),
		.rdata0 (prev_rd),
		.rdata1 (cur_x0_rd)
	);

	ibf_line_store #(.AW(AW)) u_store_b (
		.clk    (clk),
		.we     (we),
		.waddr  (wr_addr_s1),
		.wdata  (wr_data),
		.re     (accept),
		.raddr0 (rd_old_x0_addr),
		.raddr1 (rd_old_c_addr),
		.rdata0 (old_x0_rd),
		.rdata1 (old_c_rd)
	);

	ibf_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.prev_rd   (prev_rd),
		.cur_x0_rd (cur_x0_rd),
		.old_x0_rd (old_x0_rd),
		.old_c_rd  (old_c_rd),
		.we        (we),
		.wr_data   (wr_data),
		.push      (push),
		.push_word (push_word)
	);

	ibf_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.box       (box),
		.count     (fifo_count)
	);
endmodule
